### rtl/prs_pkg.sv
// Shared request and status codes and the fixed field types of the
// periodic reminder scheduler. No dependencies.
`default_nettype none

package prs_pkg;

    typedef logic [1:0]  req_t;
    typedef logic [1:0]  status_t;
    typedef logic [15:0] id_t;
    typedef logic [15:0] period_t;
    typedef logic [6:0]  held_t;

    localparam int ID_W  = 16;
    localparam int PER_W = 16;

    localparam req_t REQ_REGISTER = 2'd0;
    localparam req_t REQ_SERVE    = 2'd1;
    localparam req_t REQ_CLEAR    = 2'd2;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_FULL  = 2'd1;
    localparam status_t STATUS_EMPTY = 2'd2;

endpackage

`default_nettype wire

### rtl/periodic_reminder_scheduler_top.sv
// Periodic reminder scheduler: a min-heap of {due, id, period} entries in one
// synchronous memory. Clear, rejected and empty requests finish straight from
// idle; a register sifts up one heap level per step, and a serve reads the
// root and then the left and, if present, right child at each sift-down level.
// A new word is taken in the cycle its result strobes. Reset empties the heap;
// the entry memory itself is not cleared. Uses prs_pkg, prs_ctrl and prs_mem.
`default_nettype none

module periodic_reminder_scheduler_top #(
    parameter int HEAP_DEPTH = 64,
    parameter int TIME_BITS  = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire prs_pkg::req_t      req_type,
    input  wire prs_pkg::id_t       user_id,
    input  wire prs_pkg::period_t   period_ticks,
    output logic                    done,
    output prs_pkg::id_t            served_id,
    output prs_pkg::status_t        status,
    output prs_pkg::held_t          entries_held
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int DW = TIME_BITS + prs_pkg::ID_W + prs_pkg::PER_W;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [DW-1:0] mem_rdata;

    prs_ctrl #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .TIME_BITS  (TIME_BITS),
        .AW         (AW),
        .DW         (DW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .user_id      (user_id),
        .period_ticks (period_ticks),
        .done         (done),
        .served_id    (served_id),
        .status       (status),
        .entries_held (entries_held),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    prs_mem #(
        .DEPTH (HEAP_DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

### rtl/prs_mem.sv
// Heap entry storage: one write port and one registered read port.
// Standalone; no package dependency.
`default_nettype none

module prs_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 64
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/prs_ctrl.sv
// Request sequencer of the scheduler: decodes requests, keeps the entry count
// and runs sift-up and sift-down over the heap memory. Uses prs_pkg.
`default_nettype none

module prs_ctrl #(
    parameter int HEAP_DEPTH = 64,
    parameter int TIME_BITS  = 32,
    parameter int AW         = 6,
    parameter int DW         = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire prs_pkg::req_t      req_type,
    input  wire prs_pkg::id_t       user_id,
    input  wire prs_pkg::period_t   period_ticks,
    output logic                    done,
    output prs_pkg::id_t            served_id,
    output prs_pkg::status_t        status,
    output prs_pkg::held_t          entries_held,
    output logic                    mem_we,
    output logic [AW-1:0]           mem_waddr,
    output logic [DW-1:0]           mem_wdata,
    output logic                    mem_re,
    output logic [AW-1:0]           mem_raddr,
    input  wire logic [DW-1:0]      mem_rdata
);

    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int KW = AW + 2;
    localparam logic [CW-1:0] DEPTH_C = CW'(HEAP_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROOT,
        S_SDL,
        S_SDC,
        S_SUC,
        S_WB
    } state_t;

    function automatic logic [KW-1:0] left_of(input logic [AW-1:0] p);
        left_of = (KW'(p) << 1) + KW'(1);
    endfunction

    function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] p);
        parent_of = (p - AW'(1)) >> 1;
    endfunction

    state_t            state_reg, state_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [DW-1:0]     cur_reg, cur_next;
    logic [DW-1:0]     left_reg, left_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              done_reg, done_next;
    prs_pkg::id_t      served_id_reg, served_id_next;
    prs_pkg::status_t  status_reg, status_next;

    logic [KW-1:0]         n_k;
    logic [KW-1:0]         left_k;
    logic [KW-1:0]         right_k;
    logic [KW-1:0]         best_k;
    logic [AW-1:0]         best_pos;
    logic [KW-1:0]         next_left_k;
    logic                  right_ok;
    logic                  l_lt_cur;
    logic                  r_lt_cur;
    logic                  r_lt_l;
    logic                  take_right;
    logic                  take_left;
    logic [DW-1:0]         child_data;
    logic [TIME_BITS-1:0]  root_due;
    logic [TIME_BITS:0]    due_sum;
    logic [TIME_BITS-1:0]  new_due;
    logic [AW-1:0]         par_pos;

    assign n_k     = KW'(count_reg);
    assign left_k  = left_of(pos_reg);
    assign right_k = left_k + KW'(1);
    assign par_pos = parent_of(pos_reg);

    // Child selection follows the heap rule: left wins over the parent only
    // when strictly smaller, right only when strictly smaller than the winner.
    assign right_ok    = right_k < n_k;
    assign l_lt_cur    = left_reg < cur_reg;
    assign r_lt_cur    = mem_rdata < cur_reg;
    assign r_lt_l      = mem_rdata < left_reg;
    assign take_right  = right_ok && (l_lt_cur ? r_lt_l : r_lt_cur);
    assign take_left   = !take_right && l_lt_cur;
    assign best_k      = take_right ? right_k : left_k;
    assign best_pos    = best_k[AW-1:0];
    assign child_data  = take_right ? mem_rdata : left_reg;
    assign next_left_k = left_of(best_pos);

    // The entry word is {due, id, period}, so a plain compare orders entries.
    assign root_due = mem_rdata[DW-1 -: TIME_BITS];
    assign due_sum  = {1'b0, root_due} + (TIME_BITS + 1)'(mem_rdata[prs_pkg::PER_W-1:0]);
    assign new_due  = due_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : due_sum[TIME_BITS-1:0];

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        cur_next       = cur_reg;
        left_next      = left_reg;
        count_next     = count_reg;
        done_next      = 1'b0;
        served_id_next = served_id_reg;
        status_next    = status_reg;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg;
        mem_wdata      = cur_reg;
        mem_re         = 1'b0;
        mem_raddr      = par_pos;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    served_id_next = '0;
                    status_next    = prs_pkg::STATUS_OK;
                    case (req_type)
                        prs_pkg::REQ_REGISTER:
                        begin
                            if (count_reg >= DEPTH_C)
                            begin
                                status_next = prs_pkg::STATUS_FULL;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                cur_next   = {TIME_BITS'(period_ticks), user_id, period_ticks};
                                pos_next   = count_reg[AW-1:0];
                                count_next = count_reg + CW'(1);
                                if (count_reg == '0)
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = '0;
                                    mem_wdata = {TIME_BITS'(period_ticks), user_id, period_ticks};
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    mem_re     = 1'b1;
                                    mem_raddr  = parent_of(count_reg[AW-1:0]);
                                    state_next = S_SUC;
                                end
                            end
                        end
                        prs_pkg::REQ_SERVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = prs_pkg::STATUS_EMPTY;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = '0;
                                state_next = S_ROOT;
                            end
                        end
                        prs_pkg::REQ_CLEAR:
                        begin
                            count_next = '0;
                            done_next  = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_ROOT:
            begin
                // The served entry goes back in at the root with its next due
                // time and sinks to its place; the count does not change.
                served_id_next = mem_rdata[prs_pkg::ID_W + prs_pkg::PER_W - 1 -: prs_pkg::ID_W];
                cur_next       = {new_due, mem_rdata[prs_pkg::ID_W + prs_pkg::PER_W - 1:0]};
                pos_next       = '0;
                if (n_k > KW'(1))
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = AW'(1);
                    state_next = S_SDL;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = '0;
                    mem_wdata  = {new_due, mem_rdata[prs_pkg::ID_W + prs_pkg::PER_W - 1:0]};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_SDL:
            begin
                left_next = mem_rdata;
                if (right_ok)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = right_k[AW-1:0];
                end
                state_next = S_SDC;
            end

            S_SDC:
            begin
                mem_we = 1'b1;
                if (take_left || take_right)
                begin
                    mem_wdata = child_data;
                    pos_next  = best_pos;
                    if (next_left_k < n_k)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = next_left_k[AW-1:0];
                        state_next = S_SDL;
                    end
                    else
                    begin
                        state_next = S_WB;
                    end
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_SUC:
            begin
                mem_we = 1'b1;
                if (cur_reg < mem_rdata)
                begin
                    mem_wdata = mem_rdata;
                    pos_next  = par_pos;
                    if (par_pos == '0)
                    begin
                        state_next = S_WB;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = parent_of(par_pos);
                    end
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_WB:
            begin
                mem_we     = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            cur_reg       <= '0;
            left_reg      <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            served_id_reg <= '0;
            status_reg    <= prs_pkg::STATUS_OK;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            cur_reg       <= cur_next;
            left_reg      <= left_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            served_id_reg <= served_id_next;
            status_reg    <= status_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign served_id    = served_id_reg;
    assign status       = status_reg;
    assign entries_held = prs_pkg::held_t'(count_reg);

endmodule

`default_nettype wire
